// ===== hdl/rtls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtls_pkg
// Shared widths, payload types, controller states and command/status groups.
// ----------------------------------------------------------------------------
package rtls_pkg;

	localparam int RTT_WIDTH   = 24;
	localparam int COUNT_WIDTH = 32;
	localparam int SUM_WIDTH   = 56;
	localparam int SQSUM_WIDTH = 64;
	localparam int DIV_WIDTH   = 64;
	localparam int RATE_WIDTH  = 16;
	localparam int ROOT_WIDTH  = DIV_WIDTH / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_WIDTH);
	localparam int ROOT_CNT_W  = $clog2(ROOT_WIDTH);

	localparam logic [1:0] FUNC_REPLY = 2'd0;
	localparam logic [1:0] FUNC_NACK  = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	typedef struct packed {
		logic [1:0]           func;
		logic [RTT_WIDTH-1:0] rtt;
	} in_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] sent_count;
		logic [COUNT_WIDTH-1:0] received_count;
		logic [COUNT_WIDTH-1:0] nacked_count;
		logic [RTT_WIDTH-1:0]   rtt_min;
		logic [RTT_WIDTH-1:0]   rtt_max;
		logic [RTT_WIDTH-1:0]   rtt_mean;
		logic [RTT_WIDTH-1:0]   rtt_deviation;
		logic [RATE_WIDTH-1:0]  loss_rate;
		logic [RATE_WIDTH-1:0]  nack_rate;
		logic                   rates_valid;
		logic                   rtt_valid;
	} out_t;

	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_MSQ,
		DIV_LOSS,
		DIV_NACK
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_UPDATE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_VAR,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     square;
		logic     update;
		logic     div_start;
		logic     div_latch;
		div_sel_t div_sel;
		logic     mul;
		logic     var_load;
		logic     sqrt_start;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} status_t;

endpackage

// ===== hdl/round_trip_latency_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_trip_latency_statistics
// Probe outcome statistics: counts, min/max, mean, deviation and rates.
// ----------------------------------------------------------------------------
//  channel | signals                       | carries
//  in      | in_valid, in_ready, in_data   | one probe outcome per beat
//  out     | out_valid, out_ready, out_data| one statistics beat per input
//
// out_valid rises after an accept once the square, the update, four
// divisions on the shared divider, the mean squared, the variance and
// the root are done and the result register is free
// one item is in flight at a time; in_ready is high only while idle
// the result register lets the next item start while a result waits
// reset clears all totals at once; min starts at all ones
module round_trip_latency_statistics
	import rtls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t    cmd;
	status_t status;

	rtls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rtls_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/rtls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtls_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtls_div
	import rtls_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DIV_WIDTH-1:0]   dividend,
	input  logic [COUNT_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [DIV_WIDTH-1:0]   quotient
);

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [DIV_WIDTH-1:0]   quo_q;
	logic [COUNT_WIDTH-1:0] div_q;
	logic [COUNT_WIDTH:0]   shifted;
	logic                   ge;

	assign shifted = {rem_q, quo_q[DIV_WIDTH-1]};
	assign ge      = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? COUNT_WIDTH'(shifted - {1'b0, div_q}) : shifted[COUNT_WIDTH-1:0];
			quo_q <= {quo_q[DIV_WIDTH-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/rtls_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtls_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rtls_sqrt
	import rtls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIV_WIDTH-1:0]  value,
	output logic                  done,
	output logic [ROOT_WIDTH-1:0] root
);

	logic                  busy_q;
	logic                  done_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic [ROOT_WIDTH+1:0] rem_q;
	logic [ROOT_WIDTH-1:0] root_q;
	logic [DIV_WIDTH-1:0]  val_q;
	logic [ROOT_WIDTH+3:0] shifted;
	logic [ROOT_WIDTH+3:0] trial;
	logic                  ge;

	assign shifted = {rem_q, val_q[DIV_WIDTH-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ROOT_CNT_W'(ROOT_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= value;
		end else if (busy_q) begin
			rem_q  <= ge ? (ROOT_WIDTH+2)'(shifted - trial) : shifted[ROOT_WIDTH+1:0];
			root_q <= {root_q[ROOT_WIDTH-2:0], ge};
			val_q  <= {val_q[DIV_WIDTH-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/rtls_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtls_datapath
// Running totals, shared divider and square root, and the result register.
// ----------------------------------------------------------------------------
module rtls_datapath
	import rtls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output status_t status,
	input  in_t     in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output out_t    out_data
);

	logic [1:0]             func_q;
	logic [RTT_WIDTH-1:0]   rtt_q;
	logic [2*RTT_WIDTH-1:0] sq_q;
	logic [COUNT_WIDTH-1:0] sent_q, recv_q, nack_q;
	logic [RTT_WIDTH-1:0]   min_q, max_q;
	logic [SUM_WIDTH-1:0]   sum_q;
	logic [SQSUM_WIDTH-1:0] sqsum_q;
	logic [RTT_WIDTH-1:0]   mean_q;
	logic [DIV_WIDTH-1:0]   msq_q;
	logic [RATE_WIDTH-1:0]  loss_q, nrate_q;
	logic [2*RTT_WIDTH-1:0] m2_q;
	logic [DIV_WIDTH-1:0]   var_q;
	logic                   out_valid_q;
	out_t                   out_q;

	logic [SUM_WIDTH:0]     sum_next;
	logic [SQSUM_WIDTH:0]   sqsum_next;
	logic [COUNT_WIDTH:0]   done_cnt;
	logic [COUNT_WIDTH-1:0] lost;
	logic [DIV_WIDTH-1:0]   dividend;
	logic [COUNT_WIDTH-1:0] divisor;
	logic [DIV_WIDTH-1:0]   quotient;
	logic [ROOT_WIDTH-1:0]  root;
	logic [RATE_WIDTH-1:0]  rate_sat;

	function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	assign sum_next   = {1'b0, sum_q} + (SUM_WIDTH+1)'(rtt_q);
	assign sqsum_next = {1'b0, sqsum_q} + (SQSUM_WIDTH+1)'(sq_q);

	// received plus nacked can pass sent once counters saturate
	assign done_cnt = {1'b0, recv_q} + {1'b0, nack_q};
	assign lost     = (done_cnt >= {1'b0, sent_q}) ? '0 : COUNT_WIDTH'({1'b0, sent_q} - done_cnt);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_MEAN: begin
				dividend = DIV_WIDTH'(sum_q);
				divisor  = recv_q;
			end
			DIV_MSQ: begin
				dividend = DIV_WIDTH'(sqsum_q);
				divisor  = recv_q;
			end
			DIV_LOSS: begin
				dividend = DIV_WIDTH'({lost, {RATE_WIDTH{1'b0}}});
				divisor  = sent_q;
			end
			DIV_NACK: begin
				dividend = DIV_WIDTH'({nack_q, {RATE_WIDTH{1'b0}}});
				divisor  = sent_q;
			end
			default: begin
				dividend = '0;
				divisor  = '0;
			end
		endcase
	end

	assign rate_sat = (|quotient[DIV_WIDTH-1:RATE_WIDTH]) ? '1 : quotient[RATE_WIDTH-1:0];

	rtls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (status.div_done),
		.quotient (quotient)
	);

	rtls_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.value  (var_q),
		.done   (status.sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q  <= '0;
			recv_q  <= '0;
			nack_q  <= '0;
			min_q   <= '1;
			max_q   <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else if (cmd.update) begin
			unique case (func_q)
				FUNC_REPLY: begin
					sent_q <= count_up(sent_q);
					recv_q <= count_up(recv_q);
					if (rtt_q < min_q) min_q <= rtt_q;
					if (rtt_q > max_q) max_q <= rtt_q;
					sum_q   <= sum_next[SUM_WIDTH] ? '1 : sum_next[SUM_WIDTH-1:0];
					sqsum_q <= sqsum_next[SQSUM_WIDTH] ? '1 : sqsum_next[SQSUM_WIDTH-1:0];
				end
				FUNC_NACK: begin
					sent_q <= count_up(sent_q);
					nack_q <= count_up(nack_q);
				end
				FUNC_TIMEOUT: begin
					sent_q <= count_up(sent_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_data.func;
			rtt_q  <= in_data.rtt;
		end
		if (cmd.square) sq_q <= rtt_q * rtt_q;
		if (cmd.div_latch) begin
			unique case (cmd.div_sel)
				DIV_MEAN: mean_q <= (|quotient[DIV_WIDTH-1:RTT_WIDTH]) ? '1
					: quotient[RTT_WIDTH-1:0];
				DIV_MSQ:  msq_q   <= quotient;
				DIV_LOSS: loss_q  <= rate_sat;
				DIV_NACK: nrate_q <= rate_sat;
				default: begin
				end
			endcase
		end
		if (cmd.mul) m2_q <= mean_q * mean_q;
		if (cmd.var_load) var_q <= (msq_q > DIV_WIDTH'(m2_q)) ? msq_q - DIV_WIDTH'(m2_q) : '0;
		if (cmd.out_load) begin
			out_q.sent_count     <= sent_q;
			out_q.received_count <= recv_q;
			out_q.nacked_count   <= nack_q;
			out_q.rates_valid    <= |sent_q;
			out_q.rtt_valid      <= |recv_q;
			out_q.loss_rate      <= (|sent_q) ? loss_q : '0;
			out_q.nack_rate      <= (|sent_q) ? nrate_q : '0;
			out_q.rtt_min        <= (|recv_q) ? min_q : '0;
			out_q.rtt_max        <= (|recv_q) ? max_q : '0;
			out_q.rtt_mean       <= (|recv_q) ? mean_q : '0;
			out_q.rtt_deviation  <= !(|recv_q) ? '0
				: (|root[ROOT_WIDTH-1:RTT_WIDTH]) ? '1 : root[RTT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

// ===== hdl/rtls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtls_ctrl
// Sequencer: square, update, four divisions, mean squared, variance, root, result hand-off.
// ----------------------------------------------------------------------------
module rtls_ctrl
	import rtls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t   state_q, state_d;
	div_sel_t sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= DIV_MEAN;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				sel_d      = DIV_MEAN;
				state_d    = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.div_latch = 1'b1;
					if (sel_q == DIV_NACK) begin
						state_d = ST_MUL;
					end else begin
						sel_d   = div_sel_t'(sel_q + 2'd1);
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_VAR;
			end
			ST_VAR: begin
				cmd.var_load = 1'b1;
				state_d      = ST_SQRT_GO;
			end
			ST_SQRT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (status.sqrt_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the result register is free
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rtls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtls_checker
// Port-level checks on the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module rtls_checker
	import rtls_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// a waiting input beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while waiting");

	// one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rtt_valid |-> out_data.rtt_min <= out_data.rtt_max
			&& out_data.rtt_mean <= out_data.rtt_max)
		else $error("rtt figures out of order");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.received_count <= out_data.sent_count
			&& (out_data.rates_valid || (out_data.loss_rate == '0
			&& out_data.nack_rate == '0)))
		else $error("counts or rates inconsistent");

endmodule

bind round_trip_latency_statistics rtls_checker u_rtls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
